### hdl/free_list_slot_allocator_assert.svh
// Assertion macros for the free-list slot allocator checkers.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef FREE_LIST_SLOT_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_SLOT_ALLOCATOR_ASSERT_SVH

// generic clocked check, off while reset is asserted
`define FSA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// signal holds while the response word is stalled
`define FSA_HOLD(lbl, vld, rdy, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

### hdl/fsa_pkg.sv
// Free-list slot allocator package: sizes, mode, status and register codes.
// No dependencies.
`default_nettype none

package fsa_pkg;

	localparam int MaxSlots = 1024;
	localparam int IdxW     = $clog2(MaxSlots);
	localparam int CntW     = IdxW + 1;
	localparam int SlotW    = 10;
	localparam int OffW     = 20;
	localparam int ByteW    = 21;
	localparam int StrideW  = 10;
	localparam int DivCntW  = $clog2(OffW);

	localparam logic [CntW-1:0] EndMark  = CntW'(MaxSlots);
	localparam logic [CntW-1:0] CapLimit = CntW'(MaxSlots);

	typedef enum logic {
		REG_CAP    = 1'b0,
		REG_STRIDE = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_ALLOC    = 2'd0,
		MODE_FREE     = 2'd1,
		MODE_PEAK_RST = 2'd2,
		MODE_INIT     = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_INACTIVE = 3'd2,
		ST_BAD_OFF  = 3'd3,
		ST_NONE_OUT = 3'd4
	} status_t;

endpackage

`default_nettype wire

### hdl/fsa_ifs.sv
// Request and response channel interfaces of the free-list slot allocator.
// Depends on fsa_pkg.
`default_nettype none

interface fsa_req_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        mode;
	logic signed [fsa_pkg::ByteW-1:0]  byte_offset;

	modport source (output valid, mode, byte_offset, input ready);
	modport sink (input valid, mode, byte_offset, output ready);
endinterface

interface fsa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  status;
	logic [fsa_pkg::SlotW-1:0]   slot_index;
	logic [fsa_pkg::OffW-1:0]    slot_offset;
	logic [10:0]                 in_use;
	logic [10:0]                 high_water;

	modport source (output valid, status, slot_index, slot_offset, in_use, high_water,
		input ready);
	modport sink (input valid, status, slot_index, slot_offset, in_use, high_water,
		output ready);
endinterface

`default_nettype wire

### hdl/free_list_slot_allocator.sv
// Free-list slot allocator top level: LIFO link table, sequencer, divider.
// Depends on fsa_pkg and fsa_ifs.
//
//  port    dir   words
//  req     sink  mode, byte_offset
//  rsp     src   status, slot_index, slot_offset, in_use, high_water
//  cfg_*   in    pool_capacity (0), element_stride (1)
//
// Accept to response: allocate waits for a registered link read, free makes
// one quotient bit per cycle in the divider, reset-max and rejects go straight
// to the done state, and initialize writes one link per cycle up to capacity.
// A new word is taken once the previous one has reached the response register.
// Reset leaves the pool inactive; links are only valid after initialize.
`default_nettype none

module free_list_slot_allocator (
	input  wire logic       clk,
	input  wire logic       arst_n,
	fsa_req_if.sink         req,
	fsa_rsp_if.source       rsp,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [10:0] cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_INIT  = 6'b000010,
		S_DIV   = 6'b000100,
		S_FREE  = 6'b001000,
		S_ALLOC = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	logic [fsa_pkg::CntW-1:0]    link_mem [fsa_pkg::MaxSlots];
	logic [fsa_pkg::CntW-1:0]    rd_q;
	logic                        mem_we;
	logic [fsa_pkg::IdxW-1:0]    mem_waddr;
	logic [fsa_pkg::CntW-1:0]    mem_wdata;

	logic [10:0]                 cfg_cap_q;
	logic [fsa_pkg::StrideW-1:0] cfg_stride_q;
	logic [fsa_pkg::CntW-1:0]    cap_q;
	logic [fsa_pkg::StrideW-1:0] stride_q;
	logic [fsa_pkg::CntW-1:0]    head_q;
	logic [fsa_pkg::CntW-1:0]    used_q;
	logic [fsa_pkg::CntW-1:0]    peak_q;
	logic                        on_q;

	logic [fsa_pkg::IdxW-1:0]    ctr_q;
	logic [fsa_pkg::DivCntW-1:0] div_cnt_q;
	logic [fsa_pkg::StrideW-1:0] rem_q;
	logic [fsa_pkg::OffW-1:0]    dvd_q;
	logic [fsa_pkg::OffW-1:0]    off_q;

	logic [2:0]                  res_status_q;
	logic [fsa_pkg::SlotW-1:0]   res_idx_q;
	logic [fsa_pkg::OffW-1:0]    res_off_q;

	logic                        rsp_valid_q;
	logic [2:0]                  rsp_status_q;
	logic [fsa_pkg::SlotW-1:0]   rsp_idx_q;
	logic [fsa_pkg::OffW-1:0]    rsp_off_q;
	logic [10:0]                 rsp_used_q;
	logic [10:0]                 rsp_peak_q;

	logic                        accept;
	logic [2:0]                  acc_status;
	state_t                      acc_state;
	logic [fsa_pkg::CntW-1:0]    cap_clamp;
	logic                        init_last;
	logic [fsa_pkg::CntW-1:0]    init_link;
	logic [fsa_pkg::StrideW:0]   div_trial;
	logic [fsa_pkg::StrideW:0]   div_diff;
	logic                        div_ge;
	logic [fsa_pkg::OffW-1:0]    alloc_off;
	logic                        free_bad;
	logic                        rsp_free;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	assign cap_clamp = (fsa_pkg::CntW'(cfg_cap_q) > fsa_pkg::CapLimit) ? fsa_pkg::CapLimit
		: fsa_pkg::CntW'(cfg_cap_q);
	assign init_last = (fsa_pkg::CntW'(ctr_q) + fsa_pkg::CntW'(1)) == cap_q;
	assign init_link = init_last ? fsa_pkg::EndMark : fsa_pkg::CntW'(ctr_q) + fsa_pkg::CntW'(1);

	// restoring-divide step
	assign div_trial = {rem_q, dvd_q[fsa_pkg::OffW-1]};
	assign div_diff  = div_trial - {1'b0, stride_q};
	assign div_ge    = !div_diff[fsa_pkg::StrideW];

	assign alloc_off = fsa_pkg::OffW'(head_q[fsa_pkg::IdxW-1:0]) * fsa_pkg::OffW'(stride_q);
	assign free_bad  = (rem_q != '0) || (dvd_q >= fsa_pkg::OffW'(cap_q));

	// request decode: early status and the state that follows acceptance
	always_comb begin
		acc_status = fsa_pkg::ST_OK;
		acc_state  = S_DONE;
		unique case (req.mode)
			fsa_pkg::MODE_ALLOC: begin
				if (!on_q) begin
					acc_status = fsa_pkg::ST_INACTIVE;
				end else if (head_q >= cap_q || used_q >= cap_q) begin
					acc_status = fsa_pkg::ST_EMPTY;
				end else begin
					acc_state = S_ALLOC;
				end
			end
			fsa_pkg::MODE_FREE: begin
				if (!on_q) begin
					acc_status = fsa_pkg::ST_INACTIVE;
				end else if (used_q == '0) begin
					acc_status = fsa_pkg::ST_NONE_OUT;
				end else if (req.byte_offset[fsa_pkg::ByteW-1]) begin
					acc_status = fsa_pkg::ST_BAD_OFF;
				end else begin
					acc_state = S_DIV;
				end
			end
			fsa_pkg::MODE_PEAK_RST: begin
			end
			fsa_pkg::MODE_INIT: begin
				if (cfg_cap_q == '0 || cfg_stride_q == '0) begin
					acc_status = fsa_pkg::ST_BAD_OFF;
				end else begin
					acc_state = S_INIT;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ctr_q;
		mem_wdata = init_link;
		if (state_q == S_INIT) begin
			mem_we = 1'b1;
		end else if (state_q == S_FREE && !free_bad) begin
			mem_we    = 1'b1;
			mem_waddr = dvd_q[fsa_pkg::IdxW-1:0];
			mem_wdata = head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= link_mem[head_q[fsa_pkg::IdxW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_cap_q    <= 11'd1024;
			cfg_stride_q <= fsa_pkg::StrideW'(64);
		end else if (cfg_we) begin
			if (cfg_index == fsa_pkg::REG_STRIDE) begin
				cfg_stride_q <= cfg_data[fsa_pkg::StrideW-1:0];
			end else begin
				cfg_cap_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ctr_q     <= '0;
				div_cnt_q <= fsa_pkg::DivCntW'(fsa_pkg::OffW - 1);
				rem_q     <= '0;
				dvd_q     <= req.byte_offset[fsa_pkg::OffW-1:0];
				off_q     <= req.byte_offset[fsa_pkg::OffW-1:0];
				res_idx_q <= '0;
				res_off_q <= '0;
			end
			S_INIT: begin
				ctr_q <= ctr_q + fsa_pkg::IdxW'(1);
			end
			S_DIV: begin
				div_cnt_q <= div_cnt_q - fsa_pkg::DivCntW'(1);
				rem_q     <= div_ge ? div_diff[fsa_pkg::StrideW-1:0]
					: div_trial[fsa_pkg::StrideW-1:0];
				dvd_q     <= {dvd_q[fsa_pkg::OffW-2:0], div_ge};
			end
			S_FREE: begin
				if (!free_bad) begin
					res_idx_q <= fsa_pkg::SlotW'(dvd_q);
					res_off_q <= off_q;
				end
			end
			S_ALLOC: begin
				res_idx_q <= fsa_pkg::SlotW'(head_q);
				res_off_q <= alloc_off;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
		if (state_q == S_DONE && rsp_free) begin
			rsp_status_q <= res_status_q;
			rsp_idx_q    <= res_idx_q;
			rsp_off_q    <= res_off_q;
			rsp_used_q   <= 11'(used_q);
			rsp_peak_q   <= 11'(peak_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= fsa_pkg::EndMark;
			used_q       <= '0;
			peak_q       <= '0;
			on_q         <= 1'b0;
			cap_q        <= '0;
			stride_q     <= '0;
			res_status_q <= fsa_pkg::ST_OK;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q      <= acc_state;
						res_status_q <= acc_status;
						if (req.mode == fsa_pkg::MODE_PEAK_RST) begin
							peak_q <= used_q;
						end
						if (acc_state == S_INIT) begin
							cap_q    <= cap_clamp;
							stride_q <= cfg_stride_q;
						end
					end
				end
				S_INIT: begin
					if (init_last) begin
						head_q  <= '0;
						used_q  <= '0;
						peak_q  <= '0;
						on_q    <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= S_FREE;
					end
				end
				S_FREE: begin
					if (free_bad) begin
						res_status_q <= fsa_pkg::ST_BAD_OFF;
					end else begin
						head_q <= fsa_pkg::CntW'(dvd_q);
						used_q <= used_q - fsa_pkg::CntW'(1);
					end
					state_q <= S_DONE;
				end
				S_ALLOC: begin
					head_q <= rd_q;
					used_q <= used_q + fsa_pkg::CntW'(1);
					if (used_q + fsa_pkg::CntW'(1) > peak_q) begin
						peak_q <= used_q + fsa_pkg::CntW'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.slot_index  = rsp_idx_q;
	assign rsp.slot_offset = rsp_off_q;
	assign rsp.in_use      = rsp_used_q;
	assign rsp.high_water  = rsp_peak_q;

endmodule

`default_nettype wire

### hdl/fsa_checker.sv
// Port-level checks for the free-list slot allocator, bound to the top level.
// Depends on fsa_pkg and free_list_slot_allocator_assert.svh.
`default_nettype none

`include "free_list_slot_allocator_assert.svh"

module fsa_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      rsp_valid,
	input wire logic                      rsp_ready,
	input wire logic [2:0]                rsp_status,
	input wire logic [fsa_pkg::SlotW-1:0] rsp_slot_index,
	input wire logic [fsa_pkg::OffW-1:0]  rsp_slot_offset,
	input wire logic [10:0]               rsp_in_use,
	input wire logic [10:0]               rsp_high_water
);

	`FSA_HOLD(a_rsp_valid_hold, rsp_valid, rsp_ready, rsp_valid, "response word dropped")
	`FSA_HOLD(a_rsp_index_hold, rsp_valid, rsp_ready, rsp_slot_index, "stalled index moved")
	`FSA_ASSERT(a_peak_covers_use, rsp_valid |-> (rsp_in_use <= rsp_high_water), "in_use above high_water")
	`FSA_ASSERT(a_reject_zero, (rsp_valid && rsp_status != fsa_pkg::ST_OK) |-> (rsp_slot_index == '0 && rsp_slot_offset == '0), "reject carries a slot")

endmodule

bind free_list_slot_allocator fsa_checker u_fsa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_slot_index  (rsp.slot_index),
	.rsp_slot_offset (rsp.slot_offset),
	.rsp_in_use      (rsp.in_use),
	.rsp_high_water  (rsp.high_water)
);

`default_nettype wire
